// ===== rtl/core/asfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asfr_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 12'd300;

  // frame machine status, next-state view
  typedef struct packed {
    logic [2:0] state;
    logic       hit;
  } frame_stat_t;

  // averaging unit handshake toward the ring and the top level
  typedef struct packed {
    logic rotate;
    logic done;
  } avg_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/asfr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asfr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [asfr_pkg::SAMPLE_W-1:0] din_i,
  output logic [asfr_pkg::SAMPLE_W-1:0] dout_o
);
  import asfr_pkg::*;

  logic [SAMPLE_W-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= LEVEL_RESET;
    end else if (shift_i) begin
      val_q <= din_i;
    end
  end

  assign dout_o = val_q;

endmodule

`default_nettype wire

// ===== rtl/core/asfr_avg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asfr_avg #(
  parameter int unsigned RING_DEPTH = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [asfr_pkg::SAMPLE_W-1:0] tap_i,
  output asfr_pkg::avg_stat_t           stat_o,
  output logic [asfr_pkg::SAMPLE_W-1:0] level_o
);
  import asfr_pkg::*;

  localparam int unsigned DepW  = $clog2(RING_DEPTH);
  localparam int unsigned AccW  = SAMPLE_W + DepW;
  localparam int unsigned ShW   = AccW + DepW;
  localparam int unsigned RcpW  = AccW + 1;
  localparam int unsigned ProdW = AccW + RcpW;
  // rounded-up reciprocal of the depth; exact for every sum of the ring
  localparam logic [RcpW-1:0] Recip =
    RcpW'(((64'd1 << ShW) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_SUM  = 4'b0010,
    A_DIV  = 4'b0100,
    A_DONE = 4'b1000
  } avg_state_e;

  avg_state_e          state_q, state_d;
  logic [DepW-1:0]     cnt_q, cnt_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [SAMPLE_W-1:0] level_q, level_d;
  logic [ProdW-1:0]    prod;

  assign prod = ProdW'(acc_q) * ProdW'(Recip);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    level_d = level_q;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          state_d = A_SUM;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      A_SUM: begin
        acc_d = acc_q + AccW'(tap_i);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DepW'(RING_DEPTH - 1)) begin
          state_d = A_DIV;
        end
      end
      A_DIV: begin
        level_d = prod[ShW +: SAMPLE_W];
        state_d = A_DONE;
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      level_q <= LEVEL_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign stat_o  = '{rotate: (state_q == A_SUM), done: (state_q == A_DONE)};
  assign level_o = level_q;

endmodule

`default_nettype wire

// ===== rtl/core/asfr_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asfr_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  bit_i,
  input  logic                  own_bit_i,
  input  logic [7:0]            bit_period_i,
  output asfr_pkg::frame_stat_t stat_o
);
  import asfr_pkg::*;

  typedef enum logic [6:0] {
    PH_WAIT   = 7'b0000001,
    PH_START  = 7'b0000010,
    PH_BIT1   = 7'b0000100,
    PH_BIT2   = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_PARITY = 7'b0100000,
    PH_HIT    = 7'b1000000
  } phase_e;

  localparam logic [2:0] CODE_WAIT   = 3'd0;
  localparam logic [2:0] CODE_START  = 3'd1;
  localparam logic [2:0] CODE_BIT1   = 3'd2;
  localparam logic [2:0] CODE_BIT2   = 3'd3;
  localparam logic [2:0] CODE_DATA   = 3'd4;
  localparam logic [2:0] CODE_PARITY = 3'd5;
  localparam logic [2:0] CODE_HIT    = 3'd6;

  phase_e     phase_q, phase_d;
  logic [7:0] pt_q, pt_d;
  logic       sf_q, sf_d;
  logic       fg_q, fg_d;
  logic       ds_q, ds_d;
  logic       adv;

  // transitions tested in fixed order; a dropped frame may restart in the same tick
  always_comb begin
    phase_d = phase_q;
    pt_d    = pt_q;
    sf_d    = sf_q;
    fg_d    = fg_q;
    ds_d    = ds_q;
    adv     = 1'b0;
    if (en_i) begin
      if (pt_d != 8'hFF) begin
        pt_d = pt_d + 8'd1;
      end
      if (phase_d == PH_START && !fg_d && pt_d >= bit_period_i) begin
        phase_d = PH_WAIT;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_START && fg_d && sf_d && pt_d >= bit_period_i) begin
        phase_d = PH_BIT1;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_BIT1 && !fg_d && pt_d >= bit_period_i) begin
        phase_d = PH_WAIT;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_BIT1 && fg_d && sf_d && pt_d >= bit_period_i) begin
        phase_d = PH_BIT2;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_BIT2 && !fg_d && pt_d >= bit_period_i) begin
        phase_d = PH_WAIT;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_BIT2 && fg_d && sf_d && pt_d >= bit_period_i) begin
        phase_d = PH_DATA;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_DATA && pt_d >= bit_period_i) begin
        phase_d = PH_PARITY; pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_WAIT && bit_i) begin
        phase_d = PH_START; pt_d = '0; sf_d = 1'b0;
        fg_d    = 1'b1;
        ds_d    = 1'b0;
      end
      if (phase_d == PH_PARITY && !fg_d && pt_d >= bit_period_i) begin
        phase_d = PH_WAIT;  pt_d = '0; sf_d = 1'b0;
      end
      if (phase_d == PH_PARITY && fg_d && sf_d && pt_d >= bit_period_i) begin
        phase_d = PH_HIT;   pt_d = '0; sf_d = 1'b0;
      end
      adv = 1'b1;
    end
    // one sample on entry to each bit state
    if (adv && !sf_d) begin
      unique case (phase_d)
        PH_START, PH_BIT1: begin
          if (!bit_i) fg_d = 1'b0;
          sf_d = 1'b1;
        end
        PH_BIT2: begin
          if (bit_i) fg_d = 1'b0;
          sf_d = 1'b1;
        end
        PH_DATA: begin
          if (bit_i == own_bit_i) begin
            ds_d = bit_i;
          end else begin
            fg_d = 1'b0;
          end
          sf_d = 1'b1;
        end
        PH_PARITY: begin
          if (bit_i == ds_d) fg_d = 1'b0;
          sf_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      pt_q    <= '0;
      sf_q    <= 1'b0;
      fg_q    <= 1'b1;
      ds_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pt_q    <= pt_d;
      sf_q    <= sf_d;
      fg_q    <= fg_d;
      ds_q    <= ds_d;
    end
  end

  always_comb begin
    stat_o.hit = (phase_d == PH_HIT);
    unique case (phase_d)
      PH_WAIT:   stat_o.state = CODE_WAIT;
      PH_START:  stat_o.state = CODE_START;
      PH_BIT1:   stat_o.state = CODE_BIT1;
      PH_BIT2:   stat_o.state = CODE_BIT2;
      PH_DATA:   stat_o.state = CODE_DATA;
      PH_PARITY: stat_o.state = CODE_PARITY;
      PH_HIT:    stat_o.state = CODE_HIT;
      default:   stat_o.state = CODE_WAIT;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/adaptive_slicer_frame_receiver_top.sv =====
// Adaptive slicer with frame receiver.
// s_axis carries one 12-bit light sample per tick; m_axis returns one result
// item per sample: sliced bit, frame state, current level and the sticky hit.
// cfg_* writes margin, team bit, bit period, sample and update intervals;
// cfg_ready_o is always high and writes are expected only while idle.
// Ticks that do not refresh the level push their result into the output buffer as
// the item is taken: with the buffer empty the result appears in the cycle after
// the item is taken, and the next item may follow at once. A tick that refreshes
// the level rotates the RING_DEPTH-cell ring through the averaging unit, which sums
// the cells, scales the sum by a constant reciprocal and then publishes the new
// level with the item's result; until then s_axis_tready is low.
// Results go into a two-entry output buffer, so one item is still taken while
// a result waits; with both entries full s_axis_tready drops until m_axis
// drains. Reset (rst_ni low, asynchronous) loads the ring and level with 300,
// registers with their defaults, and returns the frame machine to waiting.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_slicer_frame_receiver_top #(
  parameter int unsigned RING_DEPTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] sliced_bit, [3:1] frame_state,
                                      // [15:4] level, [16] hit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i
);
  import asfr_pkg::*;

  localparam logic [2:0] REG_MARGIN    = 3'd0;
  localparam logic [2:0] REG_TEAM_BIT  = 3'd1;
  localparam logic [2:0] REG_BIT_PER   = 3'd2;
  localparam logic [2:0] REG_SMP_INTVL = 3'd3;
  localparam logic [2:0] REG_UPD_INTVL = 3'd4;

  // configuration
  logic [11:0] margin_q;
  logic        team_q;
  logic [7:0]  bper_q;
  logic [9:0]  sintv_q;
  logic [11:0] uintv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= 12'd250;
      team_q   <= 1'b0;
      bper_q   <= 8'd20;
      sintv_q  <= 10'd250;
      uintv_q  <= 12'd1000;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_MARGIN:    margin_q <= cfg_data_i;
        REG_TEAM_BIT:  team_q   <= cfg_data_i[0];
        REG_BIT_PER:   bper_q   <= cfg_data_i[7:0];
        REG_SMP_INTVL: sintv_q  <= cfg_data_i[9:0];
        REG_UPD_INTVL: uintv_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // slicing and clamping
  logic                accept;
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] level;
  logic [SAMPLE_W:0]   hi;
  logic                sbit;
  logic                below;
  logic [SAMPLE_W-1:0] store_val;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign smp    = s_axis_tdata[SAMPLE_W-1:0];
  assign hi     = {1'b0, level} + {1'b0, margin_q};
  assign sbit   = ({1'b0, smp} > hi);
  assign below  = (({1'b0, smp} + {1'b0, margin_q}) < {1'b0, level});

  always_comb begin
    if (sbit) begin
      store_val = hi[SAMPLE_W-1:0];
    end else if (below) begin
      store_val = level - margin_q;
    end else begin
      store_val = smp;
    end
  end

  // tick timers, saturating
  logic [9:0]  st_q, st_inc;
  logic [11:0] ut_q, ut_inc;
  logic        store_fire, upd_fire;

  assign st_inc     = (st_q != 10'h3FF) ? st_q + 10'd1 : st_q;
  assign ut_inc     = (ut_q != 12'hFFF) ? ut_q + 12'd1 : ut_q;
  assign store_fire = (st_inc >= sintv_q);
  assign upd_fire   = (ut_inc >= uintv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      ut_q <= '0;
    end else if (accept) begin
      st_q <= store_fire ? '0 : st_inc;
      ut_q <= upd_fire ? '0 : ut_inc;
    end
  end

  // ring of cells; new values enter at the head, the tail feeds back while averaging
  avg_stat_t           avg_stat;
  logic [SAMPLE_W-1:0] cell_q [RING_DEPTH];
  logic [SAMPLE_W-1:0] head_din;
  logic                ring_shift;

  assign ring_shift = (accept && store_fire) || avg_stat.rotate;
  assign head_din   = avg_stat.rotate ? cell_q[RING_DEPTH-1] : store_val;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_ring
    if (i == 0) begin : g_head
      asfr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .din_i   (head_din),
        .dout_o  (cell_q[i])
      );
    end else begin : g_body
      asfr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .din_i   (cell_q[i-1]),
        .dout_o  (cell_q[i])
      );
    end
  end

  asfr_avg #(
    .RING_DEPTH (RING_DEPTH)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && upd_fire),
    .tap_i   (cell_q[RING_DEPTH-1]),
    .stat_o  (avg_stat),
    .level_o (level)
  );

  // frame machine
  frame_stat_t fr_stat;

  asfr_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .bit_i        (sbit),
    .own_bit_i    (team_q),
    .bit_period_i (bper_q),
    .stat_o       (fr_stat)
  );

  // item waiting on a level refresh
  logic        busy_q;
  logic        pend_bit_q;
  frame_stat_t pend_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept && upd_fire) begin
      busy_q <= 1'b1;
    end else if (avg_stat.done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_bit_q  <= sbit;
      pend_stat_q <= fr_stat;
    end
  end

  // two-entry output buffer
  logic        push, pop;
  logic [23:0] res;
  logic [23:0] out_q, out_d, skid_q, skid_d;
  logic        ov_q, ov_d, sv_q, sv_d;

  assign push = (accept && !upd_fire) || avg_stat.done;
  assign pop  = ov_q && m_axis_tready;

  always_comb begin
    if (avg_stat.done) begin
      res = {7'd0, pend_stat_q.hit, level, pend_stat_q.state, pend_bit_q};
    end else begin
      res = {7'd0, fr_stat.hit, level, fr_stat.state, sbit};
    end
  end

  always_comb begin
    out_d  = out_q;
    ov_d   = ov_q;
    skid_d = skid_q;
    sv_d   = sv_q;
    if (pop) begin
      if (sv_q) begin
        out_d = skid_q;
        sv_d  = 1'b0;
      end else begin
        ov_d = 1'b0;
      end
    end
    if (push) begin
      if (!ov_d) begin
        out_d = res;
        ov_d  = 1'b1;
      end else begin
        skid_d = res;
        sv_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready = !busy_q && !(ov_q && sv_q);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && ov_q && sv_q && !pop))
    else $error("output buffer overflow");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_stat.done |-> busy_q)
    else $error("level refresh finished with no item pending");

  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_stat.hit |=> fr_stat.hit)
    else $error("hit flag cleared");

  a_no_rotate_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_stat.rotate |-> !accept)
    else $error("ring store during averaging");
`endif

endmodule

`default_nettype wire
